>>> sv/i2cms_pkg.sv
package i2cms_pkg;

    // Default depth of the message buffer.
    localparam int BUF_SIZE_DEFAULT = 16;

    // Operation codes carried on the input tuser.
    localparam logic [2:0] OP_WRITE_BUF = 3'd0;
    localparam logic [2:0] OP_START     = 3'd1;
    localparam logic [2:0] OP_RESEND    = 3'd2;
    localparam logic [2:0] OP_BUS_EVENT = 3'd3;
    localparam logic [2:0] OP_READ_BUF  = 3'd4;

    // Bus status codes with the prescaler bits cleared.
    localparam logic [7:0] NO_STATE_CODE    = 8'hF8;
    localparam logic [7:0] ST_START         = 8'h08;
    localparam logic [7:0] ST_REP_START     = 8'h10;
    localparam logic [7:0] ST_MTX_ADR_ACK   = 8'h18;
    localparam logic [7:0] ST_MTX_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_ARB_LOST      = 8'h38;
    localparam logic [7:0] ST_MRX_ADR_ACK   = 8'h40;
    localparam logic [7:0] ST_MRX_DATA_ACK  = 8'h50;
    localparam logic [7:0] ST_MRX_DATA_NACK = 8'h58;

    // One result word, first member in the highest bits.
    typedef struct packed {
        logic       pad;
        logic [7:0] read_data;
        logic [7:0] error_status;
        logic       transfer_ok;
        logic       clear_flag;
        logic       send_stop;
        logic       send_start;
        logic       send_ack;
        logic       irq_enable;
        logic       tx_load;
        logic [7:0] tx_byte;
    } result_t;

endpackage

>>> sv/i2cms_buf.sv
module i2cms_buf #(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [7:0]               wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [7:0]               rd_data_a,
    output logic [7:0]               rd_data_b
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_a_reg;
    logic [7:0] rd_data_b_reg;

    // One write port and two registered read ports; a read of the address
    // being written in the same cycle returns the new byte.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a_reg <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
            rd_data_b_reg <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_data_a_reg;
    assign rd_data_b = rd_data_b_reg;

endmodule

>>> sv/i2c_master_transfer_sequencer.sv
// Channel  | Direction | Contents
// s_*      | in        | tuser: operation; tdata: buf_index, data_byte, message_length,
//          |           |        status_code
// m_*      | out       | tdata: tx_byte, tx_load, irq_enable, send_ack, send_start,
//          |           |        send_stop, clear_flag, transfer_ok, error_status, read_data
//
// One word is accepted every cycle while the output does not stall; the buffer lookup
// fills the input register (which also holds the buffer read data), the sequencing
// decision fills the result register, and the result leaves from there.
// Reset clears pointer, length, flags and valid bits; the buffer is not cleared.
// A stalled output holds the result and stops the input register, which then
// holds its word while the input side stalls.
module i2c_master_transfer_sequencer
    import i2cms_pkg::*;
#(
    parameter int BUF_SIZE = BUF_SIZE_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // buf_index, data_byte, message_length, status_code, zeros
    input  logic [2:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // tx_byte, tx_load, irq_enable, send_ack, send_start,
                                   // send_stop, clear_flag, transfer_ok, error_status,
                                   // read_data, zero
);

    localparam int AW = $clog2(BUF_SIZE);
    localparam int PW = $clog2(BUF_SIZE + 1);
    localparam int CW = ((PW > 5) ? PW : 5) + 1;

    // Input register and its handshake.
    logic       s1_valid_reg;
    logic [2:0] s1_op_reg;
    logic [3:0] s1_idx_reg;
    logic [7:0] s1_data_reg;
    logic [4:0] s1_len_reg;
    logic [7:0] s1_code_reg;

    // Result register.
    logic    out_valid_reg;
    result_t res_reg;
    result_t res_next;

    // Sequencer state.
    logic [PW-1:0] ptr_reg;
    logic [PW-1:0] ptr_next;
    logic [PW-1:0] len_reg;
    logic [PW-1:0] len_next;
    logic          succ_reg;
    logic          succ_next;
    logic [7:0]    err_reg;
    logic [7:0]    err_next;
    logic          busy_reg;
    logic          busy_next;

    // Buffer access.
    logic          buf_wr_en;
    logic [AW-1:0] buf_wr_addr;
    logic [7:0]    buf_wr_data;
    logic          buf_rd_en;
    logic [AW-1:0] rd_addr_idx;
    logic [AW-1:0] rd_addr_ptr;
    logic [7:0]    rd_data_idx;
    logic [7:0]    rd_data_ptr;

    logic          accept;
    logic          advance;
    logic [PW-1:0] ptr_eff;
    logic [7:0]    in_code;
    logic          in_is_start;

    logic [CW-1:0] buf_c;
    logic          idx_ok;
    logic          ptr_ok;
    logic [PW-1:0] ev_ptr;
    logic [PW-1:0] rx_ptr;

    // Handshake: the input register moves on when the result register is free.
    assign advance  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;

    // Buffer reads are issued with the incoming word, using the pointer as the
    // word now finishing leaves it.
    assign ptr_eff     = advance ? ptr_next : ptr_reg;
    assign in_code     = s_tdata[24:17];
    assign in_is_start = (in_code == ST_START) || (in_code == ST_REP_START);
    assign buf_rd_en   = accept;
    assign rd_addr_idx = AW'(s_tdata[3:0]);
    assign rd_addr_ptr = in_is_start ? '0 : AW'(ptr_eff);

    i2cms_buf #(
        .DEPTH (BUF_SIZE)
    ) u_buf (
        .clk       (clk),
        .wr_en     (buf_wr_en),
        .wr_addr   (buf_wr_addr),
        .wr_data   (buf_wr_data),
        .rd_en     (buf_rd_en),
        .rd_addr_a (rd_addr_idx),
        .rd_addr_b (rd_addr_ptr),
        .rd_data_a (rd_data_idx),
        .rd_data_b (rd_data_ptr)
    );

    assign buf_c  = CW'(BUF_SIZE);
    assign idx_ok = CW'(s1_idx_reg) < buf_c;
    assign ptr_ok = CW'(ptr_reg) < buf_c;
    assign ev_ptr = ((s1_code_reg == ST_START) || (s1_code_reg == ST_REP_START)) ?
                    '0 : ptr_reg;
    assign rx_ptr = ((s1_code_reg == ST_MRX_DATA_ACK) && ptr_ok) ?
                    PW'(CW'(ptr_reg) + CW'(1)) : ptr_reg;

    // Decision for the word in the input register.
    always_comb
    begin
        ptr_next    = ptr_reg;
        len_next    = len_reg;
        succ_next   = succ_reg;
        err_next    = err_reg;
        busy_next   = busy_reg;
        buf_wr_en   = 1'b0;
        buf_wr_addr = AW'(s1_idx_reg);
        buf_wr_data = s1_data_reg;
        res_next    = '0;

        unique case (s1_op_reg)
            OP_WRITE_BUF:
            begin
                buf_wr_en = advance && !busy_reg && idx_ok;
            end
            OP_START, OP_RESEND:
            begin
                if (!busy_reg)
                begin
                    if (s1_op_reg == OP_START)
                    begin
                        len_next = (CW'(s1_len_reg) > buf_c) ? PW'(BUF_SIZE)
                                                             : PW'(s1_len_reg);
                    end
                    succ_next           = 1'b0;
                    err_next            = NO_STATE_CODE;
                    busy_next           = 1'b1;
                    res_next.send_start = 1'b1;
                    res_next.clear_flag = 1'b1;
                end
            end
            OP_READ_BUF:
            begin
                if (idx_ok)
                begin
                    res_next.read_data = rd_data_idx;
                end
            end
            OP_BUS_EVENT:
            begin
                if (busy_reg)
                begin
                    unique case (s1_code_reg)
                        ST_START, ST_REP_START, ST_MTX_ADR_ACK, ST_MTX_DATA_ACK:
                        begin
                            res_next.clear_flag = 1'b1;
                            if (ev_ptr < len_reg)
                            begin
                                res_next.tx_byte = rd_data_ptr;
                                res_next.tx_load = 1'b1;
                                ptr_next         = PW'(CW'(ev_ptr) + CW'(1));
                            end
                            else
                            begin
                                ptr_next           = ev_ptr;
                                succ_next          = 1'b1;
                                busy_next          = 1'b0;
                                res_next.send_stop = 1'b1;
                            end
                        end
                        ST_MRX_DATA_ACK, ST_MRX_ADR_ACK:
                        begin
                            buf_wr_en   = advance && ptr_ok &&
                                          (s1_code_reg == ST_MRX_DATA_ACK);
                            buf_wr_addr = AW'(ptr_reg);
                            ptr_next    = rx_ptr;
                            res_next.clear_flag = 1'b1;
                            res_next.send_ack   = (CW'(rx_ptr) + CW'(1)) < CW'(len_reg);
                        end
                        ST_MRX_DATA_NACK:
                        begin
                            buf_wr_en           = advance && ptr_ok;
                            buf_wr_addr         = AW'(ptr_reg);
                            succ_next           = 1'b1;
                            busy_next           = 1'b0;
                            res_next.clear_flag = 1'b1;
                            res_next.send_stop  = 1'b1;
                        end
                        ST_ARB_LOST:
                        begin
                            res_next.clear_flag = 1'b1;
                            res_next.send_start = 1'b1;
                        end
                        default:
                        begin
                            err_next  = s1_code_reg;
                            busy_next = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                // Unused operation codes change nothing.
            end
        endcase

        res_next.irq_enable   = busy_next;
        res_next.transfer_ok  = succ_next;
        res_next.error_status = err_next;
    end

    // Control state and valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            ptr_reg       <= '0;
            len_reg       <= '0;
            succ_reg      <= 1'b0;
            err_reg       <= NO_STATE_CODE;
            busy_reg      <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                ptr_reg       <= ptr_next;
                len_reg       <= len_next;
                succ_reg      <= succ_next;
                err_reg       <= err_next;
                busy_reg      <= busy_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= s_tuser;
            s1_idx_reg  <= s_tdata[3:0];
            s1_data_reg <= s_tdata[11:4];
            s1_len_reg  <= s_tdata[16:12];
            s1_code_reg <= s_tdata[24:17];
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

endmodule
